[rtl/plt_pkg.sv]
// plt_pkg: shared types and codes for the positional list table
// command and result beat structs, action codes, cell control flags
// no dependencies
`timescale 1ns / 1ps

package plt_pkg;

	// default list capacity
	localparam int PLT_CAPACITY = 64;

	// action codes
	localparam logic [2:0] ACT_CLEAR  = 3'd0;
	localparam logic [2:0] ACT_INSERT = 3'd1;
	localparam logic [2:0] ACT_DELETE = 3'd2;
	localparam logic [2:0] ACT_UPDATE = 3'd3;
	localparam logic [2:0] ACT_READ   = 3'd4;

	// command beat
	typedef struct packed {
		logic [2:0]         action;
		logic [6:0]         position;
		logic signed [31:0] value;
	} cmd_t;

	// result beat
	typedef struct packed {
		logic               ok;
		logic signed [31:0] read_value;
		logic [6:0]         count;
	} rsp_t;

	// flags broadcast to every cell of the row
	typedef struct packed {
		logic ins;
		logic del;
		logic upd;
		logic rd_load;
		logic rd_shift;
	} cell_ctl_t;

endpackage

[rtl/plt_cell.sv]
// plt_cell: one storage cell of the list row
// holds one entry and one read-out stage, talks to both neighbours
// depends on plt_pkg
`timescale 1ns / 1ps

module plt_cell
	import plt_pkg::*;
#(
	parameter int SW  = 6,
	parameter int IDX = 0
) (
	input  logic               clk,
	input  cell_ctl_t          ctl,
	input  logic [SW-1:0]      slot,
	input  logic signed [31:0] value,
	input  logic signed [31:0] left,
	input  logic signed [31:0] right,
	input  logic signed [31:0] rd_right,
	output logic signed [31:0] ent,
	output logic signed [31:0] rd
);

	localparam logic [SW-1:0] MY = SW'(IDX);

	logic signed [31:0] ent_q;
	logic signed [31:0] rd_q;

	// entry: write at the slot, shift up above it on insert, pull down on delete
	always_ff @(posedge clk) begin
		if ((ctl.ins || ctl.upd) && MY == slot) begin
			ent_q <= value;
		end else if (ctl.ins && MY > slot) begin
			ent_q <= left;
		end else if (ctl.del && MY >= slot) begin
			ent_q <= right;
		end
	end

	// read-out chain moving one cell a cycle towards cell zero
	always_ff @(posedge clk) begin
		if (ctl.rd_load) begin
			rd_q <= ent_q;
		end else if (ctl.rd_shift) begin
			rd_q <= rd_right;
		end
	end

	assign ent = ent_q;
	assign rd  = rd_q;

endmodule

[rtl/positional_list_table_unit.sv]
// positional_list_table_unit: top level of the positional list table
// row of plt_cell instances plus length tracking and result register
// depends on plt_pkg and plt_cell
`timescale 1ns / 1ps

// An ordered list of up to CAPACITY signed words addressed by 1-based position.
// A command is taken when start is high and busy is low; its result beat shows
// on result for one cycle with done high, in the cycle after it is taken for
// clear, insert, delete, update and any failed command, so these run one per
// cycle back to back. On insert the cells above the slot, and on delete those
// from the slot up, shift in parallel. A successful read keeps busy high while
// the entry walks down the read-out chain one cell per cycle to cell zero, and
// then delivers its beat. Storage has no reset; reset clears the length, the
// sequencer and the result register. The receiver cannot stall; each beat must be taken the cycle it is shown.
module positional_list_table_unit
	import plt_pkg::*;
#(
	parameter int CAPACITY = PLT_CAPACITY
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output rsp_t result
);

	localparam int SW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = ((LW > 7) ? LW : 7) + 1;
	localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

	typedef enum logic {ST_IDLE, ST_READ} state_t;

	state_t          state_q;
	logic [LW-1:0]   len_q;
	logic [SW-1:0]   rd_cnt_q;
	logic            done_q;
	rsp_t            result_q;

	logic               take;
	logic [CW-1:0]      pos_w;
	logic [CW-1:0]      len_w;
	logic [SW-1:0]      slot;
	logic               in_range;
	logic               ins_ok;
	cell_ctl_t          ctl;
	logic signed [31:0] ent [CAPACITY];
	logic signed [31:0] rd  [CAPACITY];

	// position checks against the current length
	assign take     = start && !busy;
	assign pos_w    = CW'(cmd.position);
	assign len_w    = CW'(len_q);
	assign slot     = SW'(pos_w - CW'(1));
	assign in_range = (pos_w != '0) && (pos_w <= len_w);
	assign ins_ok   = (pos_w != '0) && (pos_w <= len_w + CW'(1)) && (len_w < CAP_W);

	// control broadcast to the row
	always_comb begin
		ctl.ins      = take && cmd.action == ACT_INSERT && ins_ok;
		ctl.del      = take && cmd.action == ACT_DELETE && in_range;
		ctl.upd      = take && cmd.action == ACT_UPDATE && in_range;
		ctl.rd_load  = take && cmd.action == ACT_READ && in_range;
		ctl.rd_shift = (state_q == ST_READ) && (rd_cnt_q != '0);
	end

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_in;
		logic signed [31:0] right_in;
		logic signed [31:0] rd_in;
		if (i == 0) begin : g_first
			assign left_in = cmd.value;
		end else begin : g_mid_l
			assign left_in = ent[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_in = ent[i];
			assign rd_in    = rd[i];
		end else begin : g_mid_r
			assign right_in = ent[i+1];
			assign rd_in    = rd[i+1];
		end
		plt_cell #(
			.SW  (SW),
			.IDX (i)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.slot     (slot),
			.value    (cmd.value),
			.left     (left_in),
			.right    (right_in),
			.rd_right (rd_in),
			.ent      (ent[i]),
			.rd       (rd[i])
		);
	end

	// sequencer: length, read walk and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			len_q    <= '0;
			rd_cnt_q <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						result_q.read_value <= '0;
						result_q.count      <= 7'(len_q);
						result_q.ok         <= 1'b0;
						done_q              <= 1'b1;
						unique case (cmd.action)
							ACT_CLEAR: begin
								len_q          <= '0;
								result_q.ok    <= 1'b1;
								result_q.count <= '0;
							end
							ACT_INSERT: begin
								if (ins_ok) begin
									len_q          <= len_q + LW'(1);
									result_q.ok    <= 1'b1;
									result_q.count <= 7'(len_q + LW'(1));
								end
							end
							ACT_DELETE: begin
								if (in_range) begin
									len_q          <= len_q - LW'(1);
									result_q.ok    <= 1'b1;
									result_q.count <= 7'(len_q - LW'(1));
								end
							end
							ACT_UPDATE: begin
								result_q.ok <= in_range;
							end
							ACT_READ: begin
								if (in_range) begin
									done_q   <= 1'b0;
									rd_cnt_q <= slot;
									state_q  <= ST_READ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					if (rd_cnt_q == '0) begin
						result_q.ok         <= 1'b1;
						result_q.read_value <= rd[0];
						result_q.count      <= 7'(len_q);
						done_q              <= 1'b1;
						state_q             <= ST_IDLE;
					end else begin
						rd_cnt_q <= rd_cnt_q - SW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// any command other than a good read answers in the next cycle
	a_quick_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !ctl.rd_load) |=> done)
		else $error("single-cycle command gave no result beat");

	// the length never passes the capacity
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CW'(len_q) <= CAP_W))
		else $error("list length above capacity");

	// the end of a read walk always delivers its beat
	a_read_ends: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("read walk ended without a result beat");

	// no beat is shown while a read is still walking
	a_no_beat_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// a non-zero read value only comes with success
	a_value_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.read_value != 0) |-> result.ok)
		else $error("read value on a failed beat");

endmodule

[sim/positional_list_table_checker.sv]
// positional_list_table_checker: watches the command and result channels of the list table
// keeps its own copy of the list, predicts each result beat and compares it field by field
// depends on plt_pkg
`timescale 1ns / 1ps

module positional_list_table_checker
	import plt_pkg::*;
#(
	parameter int CAPACITY = PLT_CAPACITY
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  cmd_t cmd,
	input  logic done,
	input  rsp_t result,
	output int   errors,
	output int   pending
);

	// shadow of the list storage and its length
	logic [31:0] list_words [CAPACITY];
	int          list_len = 0;

	// result beats still owed by the block, oldest first
	rsp_t awaited_beats [$];
	int   fail_count = 0;

	// apply one command to the shadow list and return the beat it should give
	function automatic rsp_t apply_list_command(cmd_t c);
		rsp_t r;
		int   pos;
		int   k;
		r   = '0;
		pos = int'(c.position);
		case (c.action)
			ACT_CLEAR: begin
				list_len = 0;
				r.ok     = 1'b1;
			end
			ACT_INSERT: begin
				if (pos >= 1 && pos <= list_len + 1 && list_len < CAPACITY) begin
					for (k = list_len; k > pos - 1; k--)
						list_words[k] = list_words[k - 1];
					list_words[pos - 1] = c.value;
					list_len++;
					r.ok = 1'b1;
				end
			end
			ACT_DELETE: begin
				if (pos >= 1 && pos <= list_len) begin
					for (k = pos; k < list_len; k++)
						list_words[k - 1] = list_words[k];
					list_len--;
					r.ok = 1'b1;
				end
			end
			ACT_UPDATE: begin
				if (pos >= 1 && pos <= list_len) begin
					list_words[pos - 1] = c.value;
					r.ok = 1'b1;
				end
			end
			ACT_READ: begin
				if (pos >= 1 && pos <= list_len) begin
					r.read_value = list_words[pos - 1];
					r.ok         = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.count = list_len[6:0];
		return r;
	endfunction

	// count a failure, print only the first few
	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	// sample both channels at each edge, predict on accepted commands, compare beats
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			list_len = 0;
			awaited_beats.delete();
		end else begin
			if (done) begin
				if (awaited_beats.size() == 0) begin
					note_failure($sformatf("unexpected beat ok=%0b read_value=%0d count=%0d",
						result.ok, result.read_value, result.count));
				end else begin
					want = awaited_beats.pop_front();
					if (result.ok !== want.ok || result.read_value !== want.read_value ||
					    result.count !== want.count)
						note_failure({
							$sformatf("expected ok=%0b read_value=%0d count=%0d",
								want.ok, want.read_value, want.count),
							$sformatf(", got ok=%0b read_value=%0d count=%0d",
								result.ok, result.read_value, result.count)});
				end
			end
			if (start && !busy)
				awaited_beats.push_back(apply_list_command(cmd));
		end
		errors  <= fail_count;
		pending <= awaited_beats.size();
	end

endmodule

[sim/positional_list_table_unit_test.sv]
// positional_list_table_unit_test: stimulus and verdict for the positional list table
// directed edge cases then random grow and shrink phases; checking sits in the checker module
// depends on plt_pkg, positional_list_table_unit and positional_list_table_checker
`timescale 1ns / 1ps

module positional_list_table_unit_test;
	import plt_pkg::*;

	localparam int CAPACITY     = PLT_CAPACITY;
	localparam int RANDOM_ITEMS = 680;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = CAPACITY + 16;
	localparam int QUIET_FIRST  = 200;
	localparam int QUIET_LAST   = 400;
	localparam int SETTLE_AT    = 350;

	// codes the block does not decode
	localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	cmd_t cmd    = '0;
	logic busy;
	logic done;
	rsp_t result;
	int   errors;
	int   pending;

	int shadow_len  = 0;
	bit idle_on     = 1'b1;
	int cycle_count = 0;

	always #2 clk = ~clk;

	positional_list_table_unit #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.done  (done),
		.result(result)
	);

	positional_list_table_checker #(
		.CAPACITY(CAPACITY)
	) i_checker (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result),
		.errors (errors),
		.pending(pending)
	);

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("positional_list_table_unit: mismatch");
			$finish;
		end
	end

	function automatic cmd_t make_cmd(input logic [2:0] act, input int pos, input logic [31:0] val);
		cmd_t c;
		c.action   = act;
		c.position = pos[6:0];
		c.value    = val;
		return c;
	endfunction

	// mostly random words, sometimes the extremes
	function automatic logic [31:0] pick_value();
		case ($urandom_range(19))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// position inside 1..hi, leaning towards both ends
	function automatic int pick_position(input int hi);
		if (hi < 1)
			return 1;
		case ($urandom_range(9))
			0: return 1;
			1: return hi;
			default: return $urandom_range(hi, 1);
		endcase
	endfunction

	// one random command: mostly well formed, some noise
	function automatic cmd_t pick_command(input bit grow);
		int r;
		int mix;
		r = $urandom_range(99);
		if (r < 1)
			return make_cmd(ACT_CLEAR, $urandom_range(127), pick_value());
		if (r < 4)
			return make_cmd(3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST)),
				$urandom_range(127), pick_value());
		if (r < 12)
			return make_cmd(3'($urandom_range(ACT_READ, ACT_INSERT)), $urandom_range(127),
				pick_value());
		mix = $urandom_range(99);
		if (mix < (grow ? 55 : 20))
			return make_cmd(ACT_INSERT, pick_position(shadow_len + 1), pick_value());
		if (mix < (grow ? 70 : 70))
			return make_cmd(ACT_DELETE, pick_position(shadow_len), pick_value());
		if (mix < 85)
			return make_cmd(ACT_UPDATE, pick_position(shadow_len), pick_value());
		return make_cmd(ACT_READ, pick_position(shadow_len), pick_value());
	endfunction

	// rough length tracking, used only to aim positions
	function automatic void track_len(input cmd_t c);
		int pos;
		pos = int'(c.position);
		case (c.action)
			ACT_CLEAR:  shadow_len = 0;
			ACT_INSERT: if (pos >= 1 && pos <= shadow_len + 1 && shadow_len < CAPACITY)
				shadow_len++;
			ACT_DELETE: if (pos >= 1 && pos <= shadow_len)
				shadow_len--;
			default: begin
			end
		endcase
	endfunction

	// idle step: start low and random command bits up to the clock edge
	task automatic idle_cycle();
		start <= 1'b0;
		cmd   <= make_cmd(3'($urandom_range(7)), $urandom_range(127), $urandom);
		@(posedge clk);
	endtask

	// offer a command beat and hold it until the block takes it
	task automatic send_command(input cmd_t c);
		while (idle_on && $urandom_range(99) < 11)
			idle_cycle();
		start <= 1'b1;
		cmd   <= c;
		do
			@(posedge clk);
		while (busy);
		track_len(c);
	endtask

	// hold off until every owed beat has come back
	task automatic wait_drained();
		idle_cycle();
		while (pending != 0)
			idle_cycle();
	endtask

	initial begin
		cmd_t directed [$];
		int   n;

		// empty list, bad positions, inserts at front, back and middle, then reads, updates, deletes and unused codes
		directed.push_back(make_cmd(ACT_CLEAR, 0, 32'h0));
		directed.push_back(make_cmd(ACT_READ, 1, 32'h0));
		directed.push_back(make_cmd(ACT_DELETE, 1, 32'h0));
		directed.push_back(make_cmd(ACT_UPDATE, 1, 32'h1234_5678));
		directed.push_back(make_cmd(ACT_INSERT, 0, 32'h1111_1111));
		directed.push_back(make_cmd(ACT_INSERT, 2, 32'h2222_2222));
		directed.push_back(make_cmd(ACT_INSERT, 1, 32'h7fff_ffff));
		directed.push_back(make_cmd(ACT_INSERT, 1, 32'h8000_0000));
		directed.push_back(make_cmd(ACT_INSERT, 3, 32'h0000_0000));
		directed.push_back(make_cmd(ACT_INSERT, 2, 32'hffff_ffff));
		directed.push_back(make_cmd(ACT_READ, 1, 32'h0));
		directed.push_back(make_cmd(ACT_READ, 4, 32'h0));
		directed.push_back(make_cmd(ACT_READ, 5, 32'h0));
		directed.push_back(make_cmd(ACT_READ, 127, 32'hffff_ffff));
		directed.push_back(make_cmd(ACT_UPDATE, 4, 32'h5555_5555));
		directed.push_back(make_cmd(ACT_UPDATE, 0, 32'haaaa_aaaa));
		directed.push_back(make_cmd(ACT_DELETE, 2, 32'h0));
		directed.push_back(make_cmd(ACT_DELETE, 4, 32'h0));
		directed.push_back(make_cmd(ACT_DELETE, 3, 32'h0));
		directed.push_back(make_cmd(ACT_SPARE_FIRST, 1, 32'h0));
		directed.push_back(make_cmd(3'd6, 1, 32'h0));
		directed.push_back(make_cmd(ACT_SPARE_LAST, 1, 32'h0));
		directed.push_back(make_cmd(ACT_READ, 2, 32'h0));
		directed.push_back(make_cmd(ACT_CLEAR, 127, 32'hffff_ffff));

		// reset once at the start
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_command(directed[i]);

		// random part: alternating grow and shrink phases
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			idle_on = !(n >= QUIET_FIRST && n < QUIET_LAST);
			if (n == SETTLE_AT)
				wait_drained();
			send_command(pick_command(((n / 120) % 2) == 0));
		end

		// let every owed beat arrive, then watch for strays
		wait_drained();
		repeat (DRAIN_CYCLES)
			idle_cycle();

		if (errors == 0 && pending == 0)
			$display("positional_list_table_unit: match");
		else
			$display("positional_list_table_unit: mismatch");
		$finish;
	end

endmodule
